### hw/rtl/rtd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtd_pkg
// Shared constants and sideband type for the RTD code to temperature core.
// ---------------------------------------------------------------------------
package rtd_pkg;

  localparam int CODE_W = 15;
  localparam int OHMS_W = 16;
  localparam int RES_W  = 22;
  localparam int TEMP_W = 19;
  localparam int N_W    = CODE_W + OHMS_W;

  // Register indexes
  localparam logic REG_REFERENCE = 1'b0;
  localparam logic REG_NOMINAL   = 1'b1;

  // Callendar-Van Dusen terms scaled by 10^14
  localparam logic [30:0] CVD_D0 = 31'd1758480889;
  localparam logic [27:0] CVD_K  = 28'd231000000;
  localparam int          LHS_W  = 28 + N_W;
  // A * 10^7 * 2^16
  localparam logic [31:0] CVD_A0 = 32'd2561343488;

  localparam int SQ_W   = 32;
  localparam int QUO_W  = 2 * SQ_W - 1;

  // floor(u / 231) via reciprocal multiply
  localparam int          U_W         = 33;
  localparam int          RECIP_SHIFT = 40;
  localparam logic [32:0] RECIP       = 33'((64'd1 << RECIP_SHIFT) / 64'd231);
  localparam int          Q_W         = 2 * U_W - RECIP_SHIFT;
  localparam logic [7:0]  DIVISOR     = 8'd231;

  localparam logic [RES_W-1:0]         RES_MAX  = '1;
  localparam logic signed [TEMP_W-1:0] TEMP_SAT = 19'sd216577;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 19'sd262143;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = -19'sd262144;

  typedef struct packed {
    logic [RES_W-1:0] res;
    logic             flag;
  } side_t;

endpackage

### hw/rtl/rtd_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtd_in_if
// Converter code channel.
// ---------------------------------------------------------------------------
interface rtd_in_if;
  logic        valid;
  logic        ready;
  logic [14:0] adc_code;

  modport source (output valid, output adc_code, input ready);
  modport sink   (input valid, input adc_code, output ready);
endinterface

### hw/rtl/rtd_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtd_out_if
// Resistance and temperature result channel.
// ---------------------------------------------------------------------------
interface rtd_out_if;
  logic               valid;
  logic               ready;
  logic [21:0]        resistance_q6;
  logic signed [18:0] temperature_q6;
  logic               out_of_range;

  modport source (output valid, output resistance_q6, output temperature_q6,
                  output out_of_range, input ready);
  modport sink   (input valid, input resistance_q6, input temperature_q6,
                  input out_of_range, output ready);
endinterface

### hw/rtl/rtd_code_to_temperature_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtd_code_to_temperature_core
// RTD converter code to resistance and Callendar-Van Dusen temperature.
// ---------------------------------------------------------------------------
// Pipeline: input beat to output beat through 3 front stages,
//   63 divider stages, 32 square-root stages and 4 scaling stages.
// Throughput: one beat per cycle; the whole pipeline holds while the
//   output beat waits.
// Reset: synchronous; clears all valid bits, reference 430, nominal 100.
// ---------------------------------------------------------------------------
module rtd_code_to_temperature_core
  import rtd_pkg::*;
#(
  parameter int CODE_BITS = 15,
  parameter int FRAC_BITS = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [OHMS_W-1:0] cfg_wdata,
  rtd_in_if.sink            in_ch,
  rtd_out_if.source         out_ch
);

  localparam int MW    = OHMS_W + CODE_BITS;
  localparam int DW    = 31 + MW;
  localparam int CMP_W = (DW > LHS_W) ? DW : LHS_W;
  localparam logic [CODE_W-1:0] CODE_MASK =
    (CODE_BITS >= CODE_W) ? '1 : CODE_W'((1 << CODE_BITS) - 1);

  logic en;

  logic [OHMS_W-1:0] reference_ohms;
  logic [OHMS_W-1:0] nominal_ohms;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_ohms <= OHMS_W'(430);
      nominal_ohms   <= OHMS_W'(100);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_REFERENCE: reference_ohms <= cfg_wdata;
        REG_NOMINAL:   nominal_ohms   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: N = code * reference, M = nominal (0 taken as 1) << CODE_BITS
  logic              v1;
  logic [N_W-1:0]    n1;
  logic [MW-1:0]     m1;
  logic [OHMS_W-1:0] nom_eff;

  assign nom_eff = (nominal_ohms == '0) ? OHMS_W'(1) : nominal_ohms;

  // stage 2: products and resistance
  logic                 v2;
  logic [LHS_W-1:0]     lhs2;
  logic [DW-1:0]        rhs2;
  logic [MW-1:0]        m2;
  logic [RES_W-1:0]     res2;
  logic [N_W+FRAC_BITS-1:0] res_full;

  always_comb begin
    res_full = {n1, {FRAC_BITS{1'b0}}} >> CODE_BITS;
  end

  // stage 3: argument numerator
  logic          v3;
  logic [DW-1:0] dnum3;
  logic [MW-1:0] m3;
  side_t         s3;
  logic          over;

  assign over = CMP_W'(lhs2) > CMP_W'(rhs2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_ch.valid;
      v2 <= v1;
      v3 <= v2;
    end
    if (en) begin
      n1      <= (in_ch.adc_code & CODE_MASK) * reference_ohms;
      m1      <= {nom_eff, {CODE_BITS{1'b0}}};
      lhs2    <= CVD_K * n1;
      rhs2    <= CVD_D0 * m1;
      m2      <= m1;
      res2    <= (res_full > (N_W + FRAC_BITS)'(RES_MAX)) ? RES_MAX : RES_W'(res_full);
      dnum3   <= over ? '0 : DW'(CMP_W'(rhs2) - CMP_W'(lhs2));
      m3      <= m2;
      s3.res  <= res2;
      s3.flag <= over;
    end
  end

  // Dq = floor(dnum * 2^32 / M)
  logic             v4;
  side_t            s4;
  logic [QUO_W-1:0] dq;

  rtd_div #(
    .MW (MW),
    .QW (QUO_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vin      (v3),
    .side_in  (s3),
    .num_hi   (dnum3[DW-1:31]),
    .num_lo   ({dnum3[30:0], 32'd0}),
    .den_in   (m3),
    .vout     (v4),
    .side_out (s4),
    .quo      (dq)
  );

  logic            v5;
  side_t           s5;
  logic [SQ_W-1:0] root5;

  rtd_sqrt #(
    .SW (SQ_W)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vin      (v4),
    .side_in  (s4),
    .rad_in   ({1'b0, dq}),
    .vout     (v5),
    .side_out (s5),
    .root     (root5)
  );

  rtd_scale #(
    .FRAC_BITS (FRAC_BITS)
  ) u_scale (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vin     (v5),
    .side_in (s5),
    .root    (root5),
    .vout    (out_ch.valid),
    .res     (out_ch.resistance_q6),
    .temp    (out_ch.temperature_q6),
    .flag    (out_ch.out_of_range)
  );

endmodule

### hw/rtl/rtd_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtd_div
// Pipelined restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module rtd_div
  import rtd_pkg::*;
#(
  parameter int MW = 31,
  parameter int QW = 63
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vin,
  input  side_t         side_in,
  input  logic [MW-1:0] num_hi,
  input  logic [QW-1:0] num_lo,
  input  logic [MW-1:0] den_in,
  output logic          vout,
  output side_t         side_out,
  output logic [QW-1:0] quo
);

  logic [MW-1:0] rem [0:QW];
  logic [QW-1:0] low [0:QW];
  logic [MW-1:0] den [0:QW];
  logic          vld [0:QW];
  side_t         sd  [0:QW];

  always_comb begin
    rem[0] = num_hi;
    low[0] = num_lo;
    den[0] = den_in;
    vld[0] = vin;
    sd[0]  = side_in;
  end

  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic [MW:0] t;
    logic [MW:0] d;
    logic        ge;

    always_comb begin
      t  = {rem[g], low[g][QW-1]};
      d  = t - {1'b0, den[g]};
      ge = t >= {1'b0, den[g]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
      if (en) begin
        rem[g+1] <= ge ? d[MW-1:0] : t[MW-1:0];
        low[g+1] <= {low[g][QW-2:0], ge};
        den[g+1] <= den[g];
        sd[g+1]  <= sd[g];
      end
    end
  end

  assign vout     = vld[QW];
  assign side_out = sd[QW];
  assign quo      = low[QW];

endmodule

### hw/rtl/rtd_sqrt.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtd_sqrt
// Pipelined integer square root, one root bit per stage.
// ---------------------------------------------------------------------------
module rtd_sqrt
  import rtd_pkg::*;
#(
  parameter int SW = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            vin,
  input  side_t           side_in,
  input  logic [2*SW-1:0] rad_in,
  output logic            vout,
  output side_t           side_out,
  output logic [SW-1:0]   root
);

  localparam int RW = SW + 3;

  logic [2*SW-1:0] rad [0:SW];
  logic [RW-1:0]   rem [0:SW];
  logic [SW-1:0]   rt  [0:SW];
  logic            vld [0:SW];
  side_t           sd  [0:SW];

  always_comb begin
    rad[0] = rad_in;
    rem[0] = '0;
    rt[0]  = '0;
    vld[0] = vin;
    sd[0]  = side_in;
  end

  for (genvar g = 0; g < SW; g++) begin : g_stage
    logic [RW-1:0] cur;
    logic [RW-1:0] trial;
    logic          ge;

    always_comb begin
      cur   = {rem[g][RW-3:0], rad[g][2*SW-1 -: 2]};
      trial = RW'({rt[g], 2'b01});
      ge    = cur >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
      if (en) begin
        rem[g+1] <= ge ? cur - trial : cur;
        rt[g+1]  <= {rt[g][SW-2:0], ge};
        rad[g+1] <= {rad[g][2*SW-3:0], 2'b00};
        sd[g+1]  <= sd[g];
      end
    end
  end

  assign vout     = vld[SW];
  assign side_out = sd[SW];
  assign root     = rt[SW];

endmodule

### hw/rtl/rtd_scale.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtd_scale
// Maps the root to Celsius: (A - root) * 20 * 2^FRAC_BITS / (231 * 2^16),
// floored, saturated; four register stages ending in the output register.
// ---------------------------------------------------------------------------
module rtd_scale
  import rtd_pkg::*;
#(
  parameter int FRAC_BITS = 6
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     vin,
  input  side_t                    side_in,
  input  logic [SQ_W-1:0]          root,
  output logic                     vout,
  output logic [RES_W-1:0]         res,
  output logic signed [TEMP_W-1:0] temp,
  output logic                     flag
);

  // stage A: offset, scale, fold sign
  logic signed [33:0] x;
  logic signed [38:0] x20;
  logic signed [38:0] y;
  logic [U_W-1:0]     u_next;

  always_comb begin
    x      = $signed({2'b00, CVD_A0}) - $signed({2'b00, root});
    x20    = (39'(x) <<< 4) + (39'(x) <<< 2);
    y      = x20 >>> (16 - FRAC_BITS);
    u_next = y[38] ? U_W'(39'sd230 - y) : U_W'(y);
  end

  logic             va, vb, vc;
  side_t            sa, sb, sc;
  logic             na, nb, nc;
  logic [U_W-1:0]   ua, ub;
  logic [Q_W-1:0]   qb;
  logic [Q_W:0]     qc;

  // stages B and C: reciprocal multiply, remainder correction
  logic [2*U_W-1:0] prod;
  logic [U_W:0]     r;

  always_comb begin
    prod = ua * RECIP;
    r    = {1'b0, ub} - ((U_W + 1)'(qb) * (U_W + 1)'(DIVISOR));
  end

  // stage D: sign, saturation, flag
  logic signed [Q_W+1:0]   t;
  logic signed [TEMP_W-1:0] t_sat;

  always_comb begin
    t = nc ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
    if (t > (Q_W + 2)'(TEMP_MAX)) begin
      t_sat = TEMP_MAX;
    end else if (t < (Q_W + 2)'(TEMP_MIN)) begin
      t_sat = TEMP_MIN;
    end else begin
      t_sat = TEMP_W'(t);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va   <= 1'b0;
      vb   <= 1'b0;
      vc   <= 1'b0;
      vout <= 1'b0;
    end else if (en) begin
      va   <= vin;
      vb   <= va;
      vc   <= vb;
      vout <= vc;
    end
    if (en) begin
      sa   <= side_in;
      na   <= y[38];
      ua   <= u_next;
      sb   <= sa;
      nb   <= na;
      ub   <= ua;
      qb   <= prod[2*U_W-1:RECIP_SHIFT];
      sc   <= sb;
      nc   <= nb;
      qc   <= {1'b0, qb} + (Q_W + 1)'(r >= (U_W + 1)'(DIVISOR));
      res  <= sc.res;
      flag <= sc.flag;
      temp <= sc.flag ? TEMP_SAT : t_sat;
    end
  end

endmodule

### hw/rtl/rtd_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtd_checker
// Port-level checks for the RTD core, bound to the top level.
// ---------------------------------------------------------------------------
module rtd_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [21:0]        resistance_q6,
  input logic signed [18:0] temperature_q6,
  input logic               out_of_range
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(resistance_q6)
      && $stable(temperature_q6) && $stable(out_of_range))
    else $error("output beat changed while stalled");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> temperature_q6 == 19'sd216577)
    else $error("out of range without saturated temperature");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind rtd_code_to_temperature_core rtd_checker u_rtd_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .resistance_q6  (out_ch.resistance_q6),
  .temperature_q6 (out_ch.temperature_q6),
  .out_of_range   (out_ch.out_of_range)
);

### bench/tb_rtd_code_to_temperature_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_rtd_code_to_temperature_core
// Self-checking bench for the RTD code to resistance and temperature core.
// Directed codes and register extremes come first, then random codes under
// many resistor settings. Both channels idle at random, and the result side
// also holds off for a long stretch. An in-bench integer model predicts
// every beat, and a monitor compares each result against the oldest
// prediction.
// ---------------------------------------------------------------------------
module tb_rtd_code_to_temperature_core;
  import rtd_pkg::*;

  localparam int DRAIN_CYCLES = 110;
  localparam int STALL_LIMIT  = 3000;

  typedef struct packed {
    logic [RES_W-1:0]         res;
    logic signed [TEMP_W-1:0] temp;
    logic                     oor;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_addr = REG_REFERENCE;
  logic [OHMS_W-1:0] cfg_wdata = '0;

  rtd_in_if  in_ch ();
  rtd_out_if out_ch ();

  rtd_code_to_temperature_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [15:0] ref_ohms = 16'd430;
  logic [15:0] nom_ohms = 16'd100;
  reading_t    pending_readings[$];
  int          mismatches = 0;
  int          codes_sent = 0;
  int          readings_seen = 0;
  int          oor_seen = 0;
  int          hold_cycles = 0;
  int          idle_cycles = 0;
  bit          idle_on = 1'b1;

  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic reading_t convert_code(input logic [14:0] code);
    reading_t        o;
    longint unsigned n, m, rq, lhs, rhs, dnum, q, r, dq, s;
    longint          num, den, t;
    n = longint'(code) * longint'(ref_ohms);
    m = longint'((nom_ohms == 0) ? 16'd1 : nom_ohms) << 15;
    rq = (n << 6) >> 15;
    o.res = (rq > 64'd4194303) ? '1 : rq[RES_W-1:0];
    lhs = 64'd231000000 * n;
    rhs = 64'd1758480889 * m;
    if (lhs > rhs) begin
      o.oor = 1'b1;
      o.temp = TEMP_SAT;
    end else begin
      dnum = rhs - lhs;
      q = dnum / m;
      r = dnum % m;
      dq = (q << 32) + ((r << 32) / m);
      s = isqrt(dq);
      num = (longint'(39083) * 65536 - longint'(s)) * 20 * 64;
      den = 231 * 65536;
      if (num >= 0) t = num / den;
      else t = -((-num + den - 1) / den);
      if (t > 262143) t = 262143;
      if (t < -262144) t = -262144;
      o.oor = 1'b0;
      o.temp = t[TEMP_W-1:0];
    end
    return o;
  endfunction

  // result side: a long hold-off and random idling
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ch.ready <= !(idle_on && $urandom_range(99) < 15);
    end
  end

  always @(posedge clk) begin
    reading_t exp_r;
    if (!rst && out_ch.valid && out_ch.ready) begin
      readings_seen++;
      if (out_ch.out_of_range) oor_seen++;
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected beat res=%0d temp=%0d oor=%0b",
                   out_ch.resistance_q6, out_ch.temperature_q6, out_ch.out_of_range);
      end else begin
        exp_r = pending_readings.pop_front();
        if (out_ch.resistance_q6 !== exp_r.res || out_ch.temperature_q6 !== exp_r.temp ||
            out_ch.out_of_range !== exp_r.oor) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: exp res=%0d temp=%0d oor=%0b, got res=%0d temp=%0d oor=%0b",
                     exp_r.res, exp_r.temp, exp_r.oor, out_ch.resistance_q6,
                     out_ch.temperature_q6, out_ch.out_of_range);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("ERROR: no beat moved for %0d cycles", STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_code(input logic [14:0] code);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 15) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.adc_code = code;
    do @(posedge clk); while (!in_ch.ready);
    pending_readings.push_back(convert_code(code));
    codes_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_resistors(input logic [15:0] ref_v, input logic [15:0] nom_v);
    drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = REG_REFERENCE;
    cfg_wdata = ref_v;
    @(negedge clk);
    cfg_addr = REG_NOMINAL;
    cfg_wdata = nom_v;
    @(negedge clk);
    cfg_we = 1'b0;
    ref_ohms = ref_v;
    nom_ohms = nom_v;
  endtask

  task automatic send_directed_codes();
    send_code(15'd0);
    send_code(15'd32767);
    send_code(15'd1);
    send_code(15'd7620);
    send_code(15'd16384);
    send_code(15'h5555);
    send_code(15'h2AAA);
  endtask

  task automatic test_reset_defaults();
    send_directed_codes();
  endtask

  task automatic test_register_extremes();
    set_resistors(16'd65535, 16'd1);
    send_directed_codes();
    set_resistors(16'd0, 16'd100);
    send_code(15'd32767);
    send_code(15'd123);
    set_resistors(16'd430, 16'd0);
    send_directed_codes();
    set_resistors(16'd65535, 16'd65535);
    send_code(15'd32767);
    send_code(15'd0);
    set_resistors(16'd1, 16'd65535);
    send_code(15'd32767);
  endtask

  task automatic test_random_codes(input int phases, input int per_phase);
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(3))
        0: set_resistors(16'd430, 16'd100);
        1: set_resistors(16'd4300, 16'd1000);
        2: set_resistors(16'($urandom_range(65535)), 16'($urandom_range(65535)));
        default: set_resistors(16'($urandom_range(2000, 1)), 16'($urandom_range(400, 1)));
      endcase
      idle_on = (p != 1);
      for (int i = 0; i < per_phase; i++) send_code(15'($urandom));
    end
    idle_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    set_resistors(16'd430, 16'd100);
    hold_cycles = 400;
    for (int i = 0; i < 150; i++) send_code(15'($urandom));
  endtask

  task automatic test_sender_pause();
    for (int i = 0; i < 20; i++) send_code(15'($urandom));
    drain();
    for (int i = 0; i < 20; i++) send_code(15'($urandom));
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.adc_code = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_defaults();
    test_register_extremes();
    test_random_codes(8, 80);
    test_output_backpressure();
    test_sender_pause();
    drain();
    $display("Converted %0d codes, checked %0d results (%0d out of range)",
             codes_sent, readings_seen, oor_seen);
    $display("across register extremes, random resistor pairs and output stalls");
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### rtd_code_to_temperature_core.f
hw/rtl/rtd_pkg.sv
hw/rtl/rtd_in_if.sv
hw/rtl/rtd_out_if.sv
hw/rtl/rtd_div.sv
hw/rtl/rtd_sqrt.sv
hw/rtl/rtd_scale.sv
hw/rtl/rtd_code_to_temperature_core.sv
hw/rtl/rtd_checker.sv
bench/tb_rtd_code_to_temperature_core.sv
